>>> hdl/aabb_subtract_decompose_unit_macros.svh
// Assertion macros shared by the box subtraction RTL.
`ifndef AABB_SUBTRACT_DECOMPOSE_UNIT_MACROS_SVH
`define AABB_SUBTRACT_DECOMPOSE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ABSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define ABSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ABSD_ASSERT(lbl, prop, msg)
`define ABSD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hdl/absd_pkg.sv
// Types and constants for the box subtraction unit.
package absd_pkg;

  localparam int unsigned COORD_WIDTH = 20;
  localparam int unsigned SIDE_BITS   = 19;
  localparam int unsigned VOL_BITS    = 60;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SIDE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VOLUME = 2'd1;

  // 0.4 with 8 and with 24 fractional bits
  localparam logic [SIDE_BITS-1:0] MIN_SIDE_RST   = 19'd102;
  localparam logic [VOL_BITS-1:0]  MIN_VOLUME_RST = 60'd6710886;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [2:0] {
    SIDE_TOP    = 3'd0,
    SIDE_BOTTOM = 3'd1,
    SIDE_LEFT   = 3'd2,
    SIDE_RIGHT  = 3'd3,
    SIDE_FRONT  = 3'd4,
    SIDE_BACK   = 3'd5
  } side_e;

  typedef struct packed {
    coord_t cut_min_x;
    coord_t cut_min_y;
    coord_t cut_min_z;
    coord_t cut_max_x;
    coord_t cut_max_y;
    coord_t cut_max_z;
    coord_t hole_min_x;
    coord_t hole_min_y;
    coord_t hole_min_z;
    coord_t hole_max_x;
    coord_t hole_max_y;
    coord_t hole_max_z;
  } in_word_t;

  typedef struct packed {
    coord_t      piece_min_x;
    coord_t      piece_min_y;
    coord_t      piece_min_z;
    coord_t      piece_max_x;
    coord_t      piece_max_y;
    coord_t      piece_max_z;
    logic [2:0]  side_index;
    logic        keep;
    logic        last;
  } out_word_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    side_e  side;
    logic   last;
  } piece_t;

endpackage

>>> hdl/absd_issue.sv
// Input word hold and per-side piece selection, one piece per cycle while adv_i is high.
module absd_issue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  absd_pkg::in_word_t in_data_i,
  output logic              in_stall_o,
  input  logic              adv_i,
  output logic              piece_valid_o,
  output absd_pkg::piece_t  piece_o
);

  absd_pkg::in_word_t item_q;
  logic               item_vld_q;
  absd_pkg::side_e    cnt_q;
  logic               in_take;
  absd_pkg::piece_t   sel_d;
  absd_pkg::piece_t   piece_q;
  logic               piece_vld_q;
  absd_pkg::coord_t   cx_lo, cx_hi, cy_lo, cy_hi;

  // free once the back piece leaves this cycle
  assign in_stall_o = item_vld_q && !(adv_i && (cnt_q == absd_pkg::SIDE_BACK));
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      cnt_q      <= absd_pkg::SIDE_TOP;
    end else if (in_take) begin
      item_vld_q <= 1'b1;
      cnt_q      <= absd_pkg::SIDE_TOP;
    end else if (adv_i && item_vld_q) begin
      if (cnt_q == absd_pkg::SIDE_BACK) begin
        item_vld_q <= 1'b0;
      end else begin
        cnt_q <= absd_pkg::side_e'(3'(cnt_q) + 3'd1);
      end
    end
  end

  always_comb begin
    cy_lo = (item_q.cut_min_y > item_q.hole_min_y) ? item_q.cut_min_y : item_q.hole_min_y;
    cy_hi = (item_q.cut_max_y < item_q.hole_max_y) ? item_q.cut_max_y : item_q.hole_max_y;
    cx_lo = (item_q.cut_min_x > item_q.hole_min_x) ? item_q.cut_min_x : item_q.hole_min_x;
    cx_hi = (item_q.cut_max_x < item_q.hole_max_x) ? item_q.cut_max_x : item_q.hole_max_x;

    sel_d.min_x = item_q.cut_min_x;
    sel_d.min_y = item_q.cut_min_y;
    sel_d.min_z = item_q.cut_min_z;
    sel_d.max_x = item_q.cut_max_x;
    sel_d.max_y = item_q.cut_max_y;
    sel_d.max_z = item_q.cut_max_z;
    sel_d.side  = cnt_q;
    sel_d.last  = (cnt_q == absd_pkg::SIDE_BACK);

    unique case (cnt_q)
      absd_pkg::SIDE_TOP: begin
        sel_d.min_y = item_q.hole_max_y;
      end
      absd_pkg::SIDE_BOTTOM: begin
        sel_d.max_y = item_q.hole_min_y;
      end
      absd_pkg::SIDE_LEFT: begin
        sel_d.max_x = item_q.hole_min_x;
        sel_d.min_y = cy_lo;
        sel_d.max_y = cy_hi;
      end
      absd_pkg::SIDE_RIGHT: begin
        sel_d.min_x = item_q.hole_max_x;
        sel_d.min_y = cy_lo;
        sel_d.max_y = cy_hi;
      end
      absd_pkg::SIDE_FRONT: begin
        sel_d.min_x = cx_lo;
        sel_d.max_x = cx_hi;
        sel_d.min_y = cy_lo;
        sel_d.max_y = cy_hi;
        sel_d.min_z = item_q.hole_max_z;
      end
      absd_pkg::SIDE_BACK: begin
        sel_d.min_x = cx_lo;
        sel_d.max_x = cx_hi;
        sel_d.min_y = cy_lo;
        sel_d.max_y = cy_hi;
        sel_d.max_z = item_q.hole_min_z;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piece_vld_q <= 1'b0;
    end else if (adv_i) begin
      piece_vld_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      piece_q <= sel_d;
    end
  end

  assign piece_valid_o = piece_vld_q;
  assign piece_o       = piece_q;

endmodule

>>> hdl/aabb_subtract_decompose_unit.sv
// Box subtraction unit: splits a cut box around a hole box into six pieces.
//
// Input channel in_valid_i/in_stall_o/in_data_i carries one cut box and one
// hole box per word. Each accepted word yields six result words on
// out_valid_o/out_stall_i/out_data_o, in the order top, bottom, left, right,
// front, back, with last set on the back piece and keep set where all three
// sides exceed min_side and the volume exceeds min_volume.
// The first piece passes through every stage of the pipeline below; the
// others follow one per cycle while the output is not stalled. The issue
// stage holds one input word until its six pieces are issued; the next
// input is taken in the cycle the back piece is issued.
// Pipeline: issue/select, side differences, side compare and first product,
// low partial product, high partial product, volume sum and compare.
// Registers: cfg_we_i writes min_side (index 0) or min_volume (index 1).
// Reset loads the default thresholds and empties the pipeline.
// A stall on the output holds every stage; nothing is dropped or repeated.
`include "aabb_subtract_decompose_unit_macros.svh"
module aabb_subtract_decompose_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  absd_pkg::in_word_t                    in_data_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output absd_pkg::out_word_t                   out_data_o,
  input  logic                                  cfg_we_i,
  input  logic [absd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [absd_pkg::VOL_BITS-1:0]         cfg_wdata_i
);

  localparam int unsigned W    = absd_pkg::COORD_WIDTH;
  localparam int unsigned DW   = W + 1;
  localparam int unsigned CW   = (DW > absd_pkg::SIDE_BITS + 1) ? DW : absd_pkg::SIDE_BITS + 1;
  localparam int unsigned HALF = 30;
  localparam int unsigned MW   = HALF + W;
  localparam int unsigned SUMW = ((MW > 2 * HALF) ? MW : 2 * HALF) + 1;

  logic [absd_pkg::SIDE_BITS-1:0] min_side_q;
  logic [absd_pkg::VOL_BITS-1:0]  min_volume_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_side_q   <= absd_pkg::MIN_SIDE_RST;
      min_volume_q <= absd_pkg::MIN_VOLUME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        absd_pkg::REG_MIN_SIDE:   min_side_q   <= cfg_wdata_i[absd_pkg::SIDE_BITS-1:0];
        absd_pkg::REG_MIN_VOLUME: min_volume_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  logic adv;
  logic out_vld_q;

  // the whole pipe moves unless a finished word is waiting
  assign adv = !out_vld_q || !out_stall_i;

  logic             s1_vld;
  absd_pkg::piece_t s1_piece;

  absd_issue u_issue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_data_i     (in_data_i),
    .in_stall_o    (in_stall_o),
    .adv_i         (adv),
    .piece_valid_o (s1_vld),
    .piece_o       (s1_piece)
  );

  // stage 2: signed side lengths
  logic                 s2_vld_q;
  absd_pkg::piece_t     s2_piece_q;
  logic signed [DW-1:0] s2_dx_q, s2_dy_q, s2_dz_q;

  // stage 3: threshold on sides, x*y product
  logic                 s3_vld_q;
  absd_pkg::piece_t     s3_piece_q;
  logic                 s3_ok_q;
  logic [2*W-1:0]       s3_prod_q;
  logic [W-1:0]         s3_mz_q;

  // stage 4: low partial product
  logic                 s4_vld_q;
  absd_pkg::piece_t     s4_piece_q;
  logic                 s4_ok_q;
  logic                 s4_big_q;
  logic [HALF-1:0]      s4_phi_q;
  logic [MW-1:0]        s4_mlo_q;
  logic [W-1:0]         s4_mz_q;

  // stage 5: high partial product
  logic                 s5_vld_q;
  absd_pkg::piece_t     s5_piece_q;
  logic                 s5_ok_q;
  logic                 s5_big_q;
  logic [MW-1:0]        s5_mlo_q;
  logic [MW-1:0]        s5_mhi_q;

  absd_pkg::out_word_t  out_q;

  logic signed [CW-1:0] side_lim;
  logic                 ok_x, ok_y, ok_z;
  logic [63:0]          prod64;
  logic                 vol_big;
  logic [SUMW-1:0]      vol_sum;
  logic                 keep_d;

  assign side_lim = $signed(CW'({1'b0, min_side_q}));
  assign ok_x     = CW'(s2_dx_q) > side_lim;
  assign ok_y     = CW'(s2_dy_q) > side_lim;
  assign ok_z     = CW'(s2_dz_q) > side_lim;

  assign prod64   = 64'(s3_prod_q);

  // at or above 2^60 the volume beats any threshold
  assign vol_big  = s5_big_q || (|s5_mhi_q[MW-1:HALF]);
  assign vol_sum  = SUMW'({s5_mhi_q[HALF-1:0], {HALF{1'b0}}}) + SUMW'(s5_mlo_q);
  assign keep_d   = s5_ok_q && (vol_big || (vol_sum > SUMW'(min_volume_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q  <= s1_vld;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      out_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_piece_q <= s1_piece;
      s2_dx_q    <= DW'(s1_piece.max_x) - DW'(s1_piece.min_x);
      s2_dy_q    <= DW'(s1_piece.max_y) - DW'(s1_piece.min_y);
      s2_dz_q    <= DW'(s1_piece.max_z) - DW'(s1_piece.min_z);

      s3_piece_q <= s2_piece_q;
      s3_ok_q    <= ok_x && ok_y && ok_z;
      s3_prod_q  <= s2_dx_q[W-1:0] * s2_dy_q[W-1:0];
      s3_mz_q    <= s2_dz_q[W-1:0];

      s4_piece_q <= s3_piece_q;
      s4_ok_q    <= s3_ok_q;
      s4_big_q   <= |prod64[63:2*HALF];
      s4_phi_q   <= prod64[2*HALF-1:HALF];
      s4_mlo_q   <= prod64[HALF-1:0] * s3_mz_q;
      s4_mz_q    <= s3_mz_q;

      s5_piece_q <= s4_piece_q;
      s5_ok_q    <= s4_ok_q;
      s5_big_q   <= s4_big_q;
      s5_mlo_q   <= s4_mlo_q;
      s5_mhi_q   <= s4_phi_q * s4_mz_q;

      out_q.piece_min_x <= s5_piece_q.min_x;
      out_q.piece_min_y <= s5_piece_q.min_y;
      out_q.piece_min_z <= s5_piece_q.min_z;
      out_q.piece_max_x <= s5_piece_q.max_x;
      out_q.piece_max_y <= s5_piece_q.max_y;
      out_q.piece_max_z <= s5_piece_q.max_z;
      out_q.side_index  <= 3'(s5_piece_q.side);
      out_q.keep        <= keep_d;
      out_q.last        <= s5_piece_q.last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  logic [5:0] pipe_vld;
  assign pipe_vld = {s1_vld, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q, out_vld_q};

  `ABSD_ASSERT(a_last_on_back,
    out_valid_o |-> (out_data_o.last == (out_data_o.side_index == 3'(absd_pkg::SIDE_BACK))),
    "last flag not on back piece")

  `ABSD_ASSERT(a_keep_positive,
    (out_valid_o && out_data_o.keep) |->
      ((out_data_o.piece_max_x > out_data_o.piece_min_x) &&
       (out_data_o.piece_max_y > out_data_o.piece_min_y) &&
       (out_data_o.piece_max_z > out_data_o.piece_min_z)),
    "kept piece with an empty side")

  `ABSD_ASSERT_NEXT(a_pipe_hold, !adv, $stable(pipe_vld),
    "pipeline moved while held")

endmodule
